@@ hdl/sidt_pkg.sv @@
// shared constants and types for the signed integer to decimal text block
package sidt_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int IN_DATA_W   = 64;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int BITS_STEP   = 1;
  localparam int STEPS       = (VALUE_WIDTH + BITS_STEP - 1) / BITS_STEP;
  localparam int PAD_W       = STEPS * BITS_STEP;
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int CNT_W       = $clog2(STEPS + 1);
  localparam int REM_W       = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

  typedef struct packed {
    logic clr;
    logic conv;
    logic shup;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

@@ hdl/sidt_cell.sv @@
// one decimal digit cell of the shift-and-add-3 chain
module sidt_cell (
  input  logic                           clk,
  input  sidt_pkg::cell_ctl_t            ctl,
  input  logic [sidt_pkg::BITS_STEP-1:0] carry_in,
  output logic [sidt_pkg::BITS_STEP-1:0] carry_out,
  input  logic [sidt_pkg::DIGIT_W-1:0]   digit_in,
  output logic [sidt_pkg::DIGIT_W-1:0]   digit_out
);
  import sidt_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] conv_val;

  always_comb begin
    logic [DIGIT_W-1:0] d;
    d = digit_r;
    carry_out = '0;
    for (int j = 0; j < BITS_STEP; j++) begin
      if (d >= ADJ_LIMIT) begin
        d = d + ADJ_ADD;
      end
      carry_out[j] = d[DIGIT_W-1];
      d = {d[DIGIT_W-2:0], carry_in[j]};
    end
    conv_val = d;
  end

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.conv) begin
      digit_nxt = conv_val;
    end else if (ctl.shup) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_out = digit_r;

endmodule

@@ hdl/signed_integer_to_decimal_text_top.sv @@
// top level: signed integer in, decimal ascii characters out
//
// channel | dir | payload
// in_     | in  | tdata[63:0] value (low VALUE_WIDTH bits used)
// out_    | out | tdata[7:0] char_code, tlast last
//
// one number at a time: the magnitude shifts through the digit cell chain
// one bit per cycle, then leading zeros are skipped (the last digit is always
// sent) and the characters go out, a minus sign first for a negative value.
// rst_n is synchronous, active low, and clears the control state.
// in the emit state a stall on out_ holds the chain, though leading zeros
// are still skipped; a new number is taken while the final character
// still waits in the output register.
module signed_integer_to_decimal_text_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sidt_pkg::IN_DATA_W-1:0]      in_tdata,   // [63:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sidt_pkg::CHAR_W-1:0]         out_tdata,  // [7:0] char_code
  output logic                                out_tlast
);
  import sidt_pkg::*;

  state_t                state_r, state_nxt;
  logic [PAD_W-1:0]      mag_r, mag_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic                  started_r, started_nxt;
  logic                  sign_r, sign_nxt;
  logic                  ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0]     ochar_r, ochar_nxt;
  logic                  olast_r, olast_nxt;

  cell_ctl_t             ctl;
  logic                  in_acc;
  logic                  out_free;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_abs;

  logic [BITS_STEP-1:0]  carry [NUM_DIGITS];
  logic [DIGIT_W-1:0]    dig   [NUM_DIGITS];
  logic [DIGIT_W-1:0]    top_digit;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ovalid_r || out_tready;
  assign raw       = in_tdata[VALUE_WIDTH-1:0];
  assign mag_abs   = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
  assign top_digit = dig[NUM_DIGITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [BITS_STEP-1:0] cin;
    logic [DIGIT_W-1:0]   din;
    if (i == 0) begin : g_low
      for (genvar j = 0; j < BITS_STEP; j++) begin : g_bit
        assign cin[j] = mag_r[PAD_W-1-j];
      end
      assign din = '0;
    end else begin : g_up
      assign cin = carry[i-1];
      assign din = dig[i-1];
    end
    sidt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .carry_in  (cin),
      .carry_out (carry[i]),
      .digit_in  (din),
      .digit_out (dig[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    started_nxt = started_r;
    sign_nxt    = sign_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    ochar_nxt   = ochar_r;
    olast_nxt   = olast_r;
    ctl         = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.clr     = 1'b1;
          mag_nxt     = PAD_W'(mag_abs);
          sign_nxt    = raw[VALUE_WIDTH-1];
          cnt_nxt     = '0;
          started_nxt = 1'b0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.conv = 1'b1;
        mag_nxt  = mag_r << BITS_STEP;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          rem_nxt   = REM_W'(NUM_DIGITS);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sign_r) begin
          if (out_free) begin
            ovalid_nxt = 1'b1;
            ochar_nxt  = CHAR_MINUS;
            olast_nxt  = 1'b0;
            sign_nxt   = 1'b0;
          end
        end else if (!started_r && top_digit == '0 && rem_r > REM_W'(1)) begin
          ctl.shup = 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (out_free) begin
          ctl.shup    = 1'b1;
          ovalid_nxt  = 1'b1;
          ochar_nxt   = CHAR_ZERO + CHAR_W'(top_digit);
          olast_nxt   = (rem_r == REM_W'(1));
          rem_nxt     = rem_r - 1'b1;
          started_nxt = 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ovalid_r  <= 1'b0;
      cnt_r     <= '0;
      rem_r     <= '0;
      started_r <= 1'b0;
      sign_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      cnt_r     <= cnt_nxt;
      rem_r     <= rem_nxt;
      started_r <= started_nxt;
      sign_r    <= sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule
